FILE: src/itp_pkg.sv
// Shared constants, types and character helpers for the infix-to-prefix converter.
package itp_pkg;

    // Expression buffer size and derived widths
    localparam int MAX_LEN   = 32;
    localparam int OUT_LIMIT = 32;
    localparam int RES_CAP   = (MAX_LEN < OUT_LIMIT) ? MAX_LEN : OUT_LIMIT;
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int RC_W      = $clog2(RES_CAP + 1);
    localparam int RC_IW     = $clog2(RES_CAP);
    // Text buffer holds two banks, one being filled while the other is converted
    localparam int TXT_AW    = IDX_W + 1;
    localparam int TXT_DEPTH = 1 << TXT_AW;

    // Character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        KIND_OPERAND,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_OPER
    } kind_t;

    // One classified character as stored in the text buffer (parentheses already swapped)
    typedef struct packed {
        logic [7:0] sym;
        kind_t      kind;
        logic [1:0] prio;
    } tok_t;

    // One finished expression handed from front to back
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } job_t;

    function automatic logic [1:0] prio_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end else if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end
        return p;
    endfunction

    function automatic logic is_operand(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // Swap parentheses and classify for the reversed scan
    function automatic tok_t classify(input logic [7:0] raw);
        tok_t t;
        t.sym = raw;
        if (raw == CH_LPAREN) begin
            t.sym = CH_RPAREN;
        end else if (raw == CH_RPAREN) begin
            t.sym = CH_LPAREN;
        end
        if (is_operand(t.sym)) begin
            t.kind = KIND_OPERAND;
        end else if (t.sym == CH_LPAREN) begin
            t.kind = KIND_OPEN;
        end else if (t.sym == CH_RPAREN) begin
            t.kind = KIND_CLOSE;
        end else begin
            t.kind = KIND_OPER;
        end
        t.prio = prio_of(t.sym);
        return t;
    endfunction

endpackage

FILE: src/itp_text_ram.sv
// Two-bank text buffer: one write port, one registered read port.
module itp_text_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [itp_pkg::TXT_AW-1:0] waddr,
    input  itp_pkg::tok_t             wdata,
    input  logic                      re,
    input  logic [itp_pkg::TXT_AW-1:0] raddr,
    output itp_pkg::tok_t             rdata
);
    import itp_pkg::*;

    tok_t mem [TXT_DEPTH];
    tok_t rdata_reg;

    // Write and registered read; read data holds while re is low
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/itp_front.sv
// Input side: accepts characters, classifies them and fills the current text bank.
module itp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_symbol,
    input  logic                       s_last,
    input  logic                       job_full,
    output logic                       job_push,
    output itp_pkg::job_t              job_out,
    output logic                       txt_we,
    output logic [itp_pkg::TXT_AW-1:0] txt_waddr,
    output itp_pkg::tok_t              txt_wdata
);
    import itp_pkg::*;

    logic             bank_reg, bank_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             has_room;
    logic [CNT_W-1:0] cnt_inc;

    // Stall only when both banks hold unfinished expressions
    assign s_tready = !job_full;
    assign accept   = s_tvalid && s_tready;
    assign has_room = cnt_reg < CNT_W'(MAX_LEN);
    assign cnt_inc  = cnt_reg + CNT_W'(1);

    // Buffer write
    assign txt_we    = accept && has_room;
    assign txt_waddr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign txt_wdata = classify(s_symbol);

    // Hand the finished expression to the back end
    assign job_push      = accept && s_last;
    assign job_out.bank  = bank_reg;
    assign job_out.count = has_room ? cnt_inc : cnt_reg;
    assign job_out.ovf   = ovf_reg || !has_room;

    always_comb begin
        bank_next = bank_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        if (accept) begin
            if (has_room) begin
                cnt_next = cnt_inc;
            end else begin
                ovf_next = 1'b1;
            end
            if (s_last) begin
                bank_next = !bank_reg;
                cnt_next  = '0;
                ovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            bank_reg <= 1'b0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            bank_reg <= bank_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

FILE: src/itp_job_fifo.sv
// Two-entry queue of finished expressions between front and back.
module itp_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  itp_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output itp_pkg::job_t head_job
);
    import itp_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full       = cnt_reg == 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head_job   = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/itp_back.sv
// Conversion engine: reversed operator-stack scan of one bank, then prefix output.
module itp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    input  itp_pkg::job_t              job,
    output logic                       job_pop,
    output logic                       txt_re,
    output logic [itp_pkg::TXT_AW-1:0] txt_raddr,
    input  itp_pkg::tok_t              txt_rdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_symbol,
    output logic                       m_last,
    output logic                       m_empty,
    output logic                       m_ovf
);
    import itp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_RELOAD,
        S_DRAIN,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    state_t           state_reg, state_next;
    state_t           ret_reg, ret_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic [7:0]       tos_reg, tos_next;
    logic [RC_W-1:0]  rc_reg, rc_next;
    logic [RC_W-1:0]  oidx_reg, oidx_next;
    logic             ovf_reg, ovf_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_symbol_reg, m_symbol_next;
    logic             m_last_reg, m_last_next;
    logic             m_empty_reg, m_empty_next;
    logic             m_ovf_reg, m_ovf_next;

    // Operator stack below the cached top, and result store
    logic [7:0]       stk_mem [MAX_LEN];
    logic [7:0]       stk_rd_reg;
    logic [7:0]       res_mem [RES_CAP];
    logic [7:0]       res_rd_reg;

    logic             stk_we, stk_re;
    logic [IDX_W-1:0] stk_wa, stk_ra;
    logic             res_re;
    logic [RC_IW-1:0] res_ra;
    logic             res_we;
    logic [RC_IW-1:0] res_wa;
    logic [7:0]       res_wd;

    // Per-cycle actions collected before the common update
    logic             emit;
    logic [7:0]       emit_sym;
    logic             pop;
    state_t           pop_ret;
    logic             push;
    logic [7:0]       push_sym;

    logic [CNT_W-1:0] sp_dec, sp_dec2, idx_dec;
    logic [RC_W-1:0]  rc_dec, oidx_dec;

    assign sp_dec   = sp_reg - CNT_W'(1);
    assign sp_dec2  = sp_reg - CNT_W'(2);
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign rc_dec   = rc_reg - RC_W'(1);
    assign oidx_dec = oidx_reg - RC_W'(1);

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        idx_next      = idx_reg;
        sp_next       = sp_reg;
        tos_next      = tos_reg;
        rc_next       = rc_reg;
        oidx_next     = oidx_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg;
        m_symbol_next = m_symbol_reg;
        m_last_next   = m_last_reg;
        m_empty_next  = m_empty_reg;
        m_ovf_next    = m_ovf_reg;
        job_pop       = 1'b0;
        txt_re        = 1'b0;
        txt_raddr     = {job.bank, idx_dec[IDX_W-1:0]};
        stk_we        = 1'b0;
        stk_wa        = sp_dec[IDX_W-1:0];
        stk_re        = 1'b0;
        stk_ra        = sp_dec2[IDX_W-1:0];
        res_re        = 1'b0;
        res_ra        = rc_dec[RC_IW-1:0];
        res_we        = 1'b0;
        res_wa        = rc_reg[RC_IW-1:0];
        res_wd        = 8'h00;
        emit          = 1'b0;
        emit_sym      = tos_reg;
        pop           = 1'b0;
        pop_ret       = S_FETCH;
        push          = 1'b0;
        push_sym      = txt_rdata.sym;

        case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    idx_next   = job.count;
                    sp_next    = '0;
                    rc_next    = '0;
                    ovf_next   = job.ovf;
                    state_next = S_FETCH;
                end
            end
            // Read the next character, scanning from the end of the text
            S_FETCH: begin
                if (idx_reg == '0) begin
                    state_next = S_DRAIN;
                end else begin
                    txt_re     = 1'b1;
                    idx_next   = idx_dec;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FETCH;
                case (txt_rdata.kind)
                    KIND_OPERAND: begin
                        emit     = 1'b1;
                        emit_sym = txt_rdata.sym;
                    end
                    KIND_OPEN: begin
                        push = 1'b1;
                    end
                    KIND_CLOSE: begin
                        if (sp_reg != '0) begin
                            pop = 1'b1;
                            if (tos_reg == CH_LPAREN) begin
                                pop_ret = S_FETCH;
                            end else begin
                                emit    = 1'b1;
                                pop_ret = S_EXEC;
                            end
                        end
                    end
                    KIND_OPER: begin
                        if (sp_reg != '0 && prio_of(tos_reg) > txt_rdata.prio) begin
                            emit    = 1'b1;
                            pop     = 1'b1;
                            pop_ret = S_EXEC;
                        end else begin
                            push = 1'b1;
                        end
                    end
                    default: begin
                        push = 1'b1;
                    end
                endcase
            end
            // Refill the cached top from the stack memory
            S_RELOAD: begin
                tos_next   = stk_rd_reg;
                state_next = ret_reg;
            end
            // Flush what is left on the stack, then start the output
            S_DRAIN: begin
                if (sp_reg != '0) begin
                    emit    = 1'b1;
                    pop     = 1'b1;
                    pop_ret = S_DRAIN;
                end else if (rc_reg == '0) begin
                    m_tvalid_next = 1'b1;
                    m_symbol_next = CH_NUL;
                    m_last_next   = 1'b1;
                    m_empty_next  = 1'b1;
                    m_ovf_next    = ovf_reg;
                    oidx_next     = '0;
                    state_next    = S_OUT_WAIT;
                end else begin
                    res_re     = 1'b1;
                    res_ra     = rc_dec[RC_IW-1:0];
                    oidx_next  = rc_dec;
                    state_next = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                m_tvalid_next = 1'b1;
                m_symbol_next = res_rd_reg;
                m_last_next   = oidx_reg == '0;
                m_empty_next  = 1'b0;
                m_ovf_next    = ovf_reg;
                state_next    = S_OUT_WAIT;
            end
            // Hold the item until taken; fetch the next one right away
            S_OUT_WAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (m_last_reg) begin
                        job_pop    = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        res_re     = 1'b1;
                        res_ra     = oidx_dec[RC_IW-1:0];
                        oidx_next  = oidx_dec;
                        state_next = S_OUT_LD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Append one character to the result
        if (emit) begin
            if (rc_reg < RC_W'(RES_CAP)) begin
                res_we  = 1'b1;
                res_wd  = emit_sym;
                rc_next = rc_reg + RC_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        // Drop the top; reload it from memory when entries remain below
        if (pop) begin
            sp_next = sp_dec;
            if (sp_reg >= CNT_W'(2)) begin
                stk_re     = 1'b1;
                ret_next   = pop_ret;
                state_next = S_RELOAD;
            end else begin
                state_next = pop_ret;
            end
        end

        // Spill the old top to memory and cache the new one
        if (push) begin
            if (sp_reg < CNT_W'(MAX_LEN)) begin
                stk_we   = sp_reg != '0;
                tos_next = push_sym;
                sp_next  = sp_reg + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_FETCH;
            idx_reg      <= '0;
            sp_reg       <= '0;
            rc_reg       <= '0;
            oidx_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            idx_reg      <= idx_next;
            sp_reg       <= sp_next;
            tos_reg      <= tos_next;
            rc_reg       <= rc_next;
            oidx_reg     <= oidx_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
            m_symbol_reg <= m_symbol_next;
            m_last_reg   <= m_last_next;
            m_empty_reg  <= m_empty_next;
            m_ovf_reg    <= m_ovf_next;
        end
    end

    // Stack memory
    always_ff @(posedge clk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= tos_reg;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
    end

    // Result memory
    always_ff @(posedge clk) begin
        if (res_we) begin
            res_mem[res_wa] <= res_wd;
        end
        if (res_re) begin
            res_rd_reg <= res_mem[res_ra];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_symbol = m_symbol_reg;
    assign m_last   = m_last_reg;
    assign m_empty  = m_empty_reg;
    assign m_ovf    = m_ovf_reg;

    // Checks
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CNT_W'(MAX_LEN))
        else $error("operator stack depth beyond capacity");

    a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= RC_W'(RES_CAP))
        else $error("result count beyond capacity");

    a_valid_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> state_reg == S_OUT_WAIT)
        else $error("output valid outside output phase");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tready && m_last_reg) |-> job_pop)
        else $error("job not released after final item");

    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job released with empty queue");

endmodule

FILE: src/infix_to_prefix_converter_top.sv
// Top level of the infix-to-prefix converter: front end, text buffer, job queue, back end.
// One character is loaded per cycle; s_tready drops only while both text banks are busy.
// Conversion fetches and evaluates each character from the end of the text; a popped
// operator may add a repeated evaluation and a reload from the registered stack read.
// Output reads items from the registered result memory, fetching each after the last is taken.
// aresetn (synchronous, active low) empties the queue, clears counts and drops m_tvalid.
module infix_to_prefix_converter_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_symbol
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] empty_res, [1] overflow
);
    import itp_pkg::*;

    logic              job_full, job_push, job_pop, job_valid;
    job_t              job_in, job_head;
    logic              txt_we, txt_re;
    logic [TXT_AW-1:0] txt_waddr, txt_raddr;
    tok_t              txt_wdata, txt_rdata;
    logic              m_empty, m_ovf;

    itp_front u_front (
        .clk       (aclk),
        .rst_n     (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_symbol  (s_tdata),
        .s_last    (s_tlast),
        .job_full  (job_full),
        .job_push  (job_push),
        .job_out   (job_in),
        .txt_we    (txt_we),
        .txt_waddr (txt_waddr),
        .txt_wdata (txt_wdata)
    );

    itp_text_ram u_text_ram (
        .clk   (aclk),
        .we    (txt_we),
        .waddr (txt_waddr),
        .wdata (txt_wdata),
        .re    (txt_re),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    itp_job_fifo u_job_fifo (
        .clk        (aclk),
        .rst_n      (aresetn),
        .push       (job_push),
        .push_job   (job_in),
        .pop        (job_pop),
        .full       (job_full),
        .head_valid (job_valid),
        .head_job   (job_head)
    );

    itp_back u_back (
        .clk       (aclk),
        .rst_n     (aresetn),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .txt_re    (txt_re),
        .txt_raddr (txt_raddr),
        .txt_rdata (txt_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_symbol  (m_tdata),
        .m_last    (m_tlast),
        .m_empty   (m_empty),
        .m_ovf     (m_ovf)
    );

    assign m_tuser = {m_ovf, m_empty};

endmodule
